/* rtl/sam_pkg.sv */
// ----------------------------------------------------------------------------
// sam_pkg
// Shared widths, register indexes, format codes, types and the format clamp
// of the saturating audio mixer.
// ----------------------------------------------------------------------------
package sam_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int CHAN_W         = 4;
  localparam int GAIN_W         = 16;
  localparam int MUTE_W         = 16;
  localparam int GAIN_FRAC_BITS = 14;
  localparam int MAX_CHANNELS   = 16;
  localparam int ACC_W          = 40;
  localparam int PROD_W         = SAMPLE_W + GAIN_W;
  localparam int MAG_Q_W        = PROD_W - GAIN_FRAC_BITS;
  localparam int TDATA_W        = ((SAMPLE_W + CHAN_W + 7) / 8) * 8;
  localparam int TDATA_PAD      = TDATA_W - SAMPLE_W - CHAN_W;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int FMT_W          = 2;

  // sample format codes; code 3 falls back to the 32-bit range
  localparam logic [FMT_W-1:0] FMT_S8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_S32 = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MUTE   = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1 << GAIN_FRAC_BITS);

  typedef struct packed {
    logic [FMT_W-1:0]  format;
    logic [GAIN_W-1:0] gain;
    logic [MUTE_W-1:0] mute;
  } sam_cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic              last;
    logic              block_end;
  } sam_tag_t;

  // clamp a wide signed value to the range of the selected format
  function automatic logic signed [SAMPLE_W-1:0] clamp_fmt(
    input logic signed [ACC_W-1:0] v,
    input logic [FMT_W-1:0]        fmt
  );
    logic signed [ACC_W-1:0] lo;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] r;
    case (fmt)
      FMT_S8: begin
        lo = ACC_W'($signed(8'h80));
        hi = ACC_W'($signed(8'h7f));
      end
      FMT_S16: begin
        lo = ACC_W'($signed(16'h8000));
        hi = ACC_W'($signed(16'h7fff));
      end
      default: begin
        lo = ACC_W'($signed({1'b1, {(SAMPLE_W-1){1'b0}}}));
        hi = ACC_W'($signed({1'b0, {(SAMPLE_W-1){1'b1}}}));
      end
    endcase
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return $signed(r[SAMPLE_W-1:0]);
  endfunction

endpackage

/* rtl/saturating_audio_mixer_top.sv */
// ----------------------------------------------------------------------------
// saturating_audio_mixer_top
// Saturating PCM mixer: gain, mute and format clamp per track, wide
// accumulation over the tracks of one channel sample.
// ----------------------------------------------------------------------------
// Usage: track samples enter on the slave stream, one transfer per track of
// one channel of one frame. s_tdata carries the sign-extended sample and the
// channel index, s_tlast marks the final track and s_tuser[0] marks the end
// of a block. On each s_tlast transfer one mixed sample leaves on the master
// stream with its channel index; m_tlast repeats the block-end flag.
// Configuration (format, gain, mute mask) is written through cfg_valid /
// cfg_index / cfg_data, always ready, and should change only while idle.
// Pipeline: a final-track transfer passes the input register, multiply stage,
// clamp stage and accumulator with output register before m_tvalid shows.
// Throughput is one transfer per cycle while the receiver does not stall.
// Reset clears the pipeline, the accumulator and loads S16, unity gain and
// no mute. When the receiver stalls, the result holds and non-final tracks
// keep flowing into the accumulator; a final-track item behind the held
// result waits until the result is taken; s_tready drops as stages fill.
// ----------------------------------------------------------------------------
module saturating_audio_mixer_top import sam_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_W-1:0]     s_tdata,   // sample_value, channel_index, zero pad
  input  logic                   s_tlast,   // last_track
  input  logic [0:0]             s_tuser,   // block_end
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_W-1:0]     m_tdata,   // mixed_sample, out_channel, zero pad
  output logic                   m_tlast,   // out_block_end
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  sam_cfg_t                   cfg;
  logic                       in_valid;
  logic signed [SAMPLE_W-1:0] in_sample;
  sam_tag_t                   in_tag;
  logic                       scale_ready;
  logic                       prod_valid;
  logic                       prod_ready;
  logic signed [SAMPLE_W-1:0] prod_value;
  sam_tag_t                   prod_tag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.format <= FMT_S16;
      cfg.gain   <= GAIN_UNITY;
      cfg.mute   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FORMAT: cfg.format <= cfg_data[FMT_W-1:0];
        CFG_GAIN:   cfg.gain   <= cfg_data[GAIN_W-1:0];
        CFG_MUTE:   cfg.mute   <= cfg_data[MUTE_W-1:0];
        default:    ;
      endcase
    end
  end

  // input register
  assign s_tready = !in_valid || scale_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample        <= $signed(s_tdata[SAMPLE_W-1:0]);
      in_tag.channel   <= s_tdata[SAMPLE_W +: CHAN_W];
      in_tag.last      <= s_tlast;
      in_tag.block_end <= s_tuser[0];
    end
  end

  sam_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (scale_ready),
    .in_sample   (in_sample),
    .in_tag      (in_tag),
    .out_valid   (prod_valid),
    .out_ready   (prod_ready),
    .out_product (prod_value),
    .out_tag     (prod_tag)
  );

  sam_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .format     (cfg.format),
    .in_valid   (prod_valid),
    .in_ready   (prod_ready),
    .in_product (prod_value),
    .in_tag     (prod_tag),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

/* rtl/sam_scale.sv */
// ----------------------------------------------------------------------------
// sam_scale
// Gain stage: magnitude times gain in one stage, sign restore and format
// clamp in the next.
// ----------------------------------------------------------------------------
module sam_scale import sam_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  sam_cfg_t                   cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  sam_tag_t                   in_tag,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_product,
  output sam_tag_t                   out_tag
);

  logic                a_valid;
  logic                a_ready;
  logic                a_neg;
  logic [MAG_Q_W-1:0]  a_q;
  sam_tag_t            a_tag;
  logic                b_ready;

  logic [SAMPLE_W-1:0] mag;
  logic                muted;
  logic [GAIN_W-1:0]   gain_eff;
  logic [PROD_W-1:0]   product;
  logic [MAG_Q_W:0]    q_ext;
  logic signed [MAG_Q_W:0] p_signed;

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    // most negative sample gives 2^31, which still fits unsigned
    mag      = in_sample[SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
    muted    = (int'(in_tag.channel) < MAX_CHANNELS) && cfg.mute[in_tag.channel];
    gain_eff = muted ? '0 : cfg.gain;
    product  = PROD_W'(mag) * PROD_W'(gain_eff);
  end

  always_comb begin
    q_ext    = {1'b0, a_q};
    p_signed = $signed(a_neg ? (~q_ext + 1'b1) : q_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      // truncation toward zero: shift the magnitude, sign comes back later
      a_q   <= product[PROD_W-1:GAIN_FRAC_BITS];
      a_neg <= in_sample[SAMPLE_W-1];
      a_tag <= in_tag;
    end
    if (b_ready && a_valid) begin
      out_product <= clamp_fmt(ACC_W'(p_signed), cfg.format);
      out_tag     <= a_tag;
    end
  end

endmodule

/* rtl/sam_accum.sv */
// ----------------------------------------------------------------------------
// sam_accum
// Saturating 40-bit accumulator and output register; closes a sum on the
// last track and clamps it to the format range.
// ----------------------------------------------------------------------------
module sam_accum import sam_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [FMT_W-1:0]           format,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_product,
  input  sam_tag_t                   in_tag,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [TDATA_W-1:0]         m_tdata,  // mixed_sample, out_channel, zero pad
  output logic                       m_tlast   // out_block_end
);

  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W:0]      sum;
  logic signed [ACC_W-1:0]    acc_next;
  logic                       out_free;
  logic                       take;
  logic signed [SAMPLE_W-1:0] mixed_sample;
  logic [CHAN_W-1:0]          out_channel;

  assign out_free = !m_tvalid || m_tready;
  // a non-final track never waits for the output side
  assign in_ready = !in_tag.last || out_free;
  assign take     = in_valid && in_ready;

  always_comb begin
    sum = (ACC_W+1)'(acc) + (ACC_W+1)'(in_product);
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_next = sum[ACC_W] ? $signed({1'b1, {(ACC_W-1){1'b0}}})
                            : $signed({1'b0, {(ACC_W-1){1'b1}}});
    end else begin
      acc_next = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        acc <= in_tag.last ? '0 : acc_next;
      end
      if (take && in_tag.last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_tag.last) begin
      mixed_sample <= clamp_fmt(acc_next, format);
      out_channel  <= in_tag.channel;
      m_tlast      <= in_tag.block_end;
    end
  end

  assign m_tdata = {{TDATA_PAD{1'b0}}, out_channel, mixed_sample};

endmodule

/* rtl/sam_checker.sv */
// ----------------------------------------------------------------------------
// sam_checker
// Port-level checks of the mixer, bound to the top level.
// ----------------------------------------------------------------------------
module sam_checker import sam_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [TDATA_W-1:0]     m_tdata,
  input logic                   m_tlast,
  input logic                   cfg_valid,
  input logic                   cfg_ready
);

  // a stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered straight after reset");

  // backpressure only ever comes from a stalled receiver
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

  // configuration writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind saturating_audio_mixer_top sam_checker u_sam_checker (.*);
